>>> rtl/core/psa_pkg.sv
// Shared constants, codes and state type of the page span allocator.
package psa_pkg;

    localparam int PAGES      = 1024;
    localparam int PAGE_SHIFT = 12;
    localparam int IDX_W      = $clog2(PAGES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ADDR_W     = 22;
    localparam int BYTES_W    = 23;
    localparam int PIU_W      = 11;

    localparam logic [1:0] REQ_RESERVE = 2'd0;
    localparam logic [1:0] REQ_ALLOC   = 2'd1;
    localparam logic [1:0] REQ_FREE    = 2'd2;
    localparam logic [1:0] REQ_QUERY   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_COMPLETE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [PIU_W-1:0] PIU_RESET = PIU_W'(1024);

    typedef enum logic [17:0] {
        S_CLEAR    = 18'b000000000000000001,
        S_IDLE     = 18'b000000000000000010,
        S_DISP     = 18'b000000000000000100,
        S_RFILL    = 18'b000000000000001000,
        S_ACNT_RD  = 18'b000000000000010000,
        S_ACNT_CHK = 18'b000000000000100000,
        S_AEND     = 18'b000000000001000000,
        S_AFILL    = 18'b000000000010000000,
        S_FWD_RD   = 18'b000000000100000000,
        S_FWD_CHK  = 18'b000000001000000000,
        S_BSET     = 18'b000000010000000000,
        S_BWD_RD   = 18'b000000100000000000,
        S_BWD_CHK  = 18'b000001000000000000,
        S_FREE_RD  = 18'b000010000000000000,
        S_FREE_CHK = 18'b000100000000000000,
        S_FREE_CLR = 18'b001000000000000000,
        S_QRY_RD   = 18'b010000000000000000,
        S_DONE     = 18'b100000000000000000
    } state_t;

endpackage

>>> rtl/core/psa_ram.sv
// Generic simple dual-port RAM with registered read.
module psa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/page_span_allocator.sv
// Top level of the page span allocator: sequencer, page table and result register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | into      | in_valid/in_stall  | req_type, byte_address, request_bytes,
//          |           |                    | pages_done
//  out     | out of    | out_valid/out_stall| span_address, span_bytes, pages_done_next,
//          |           |                    | entry_bytes, status
//  cfg     | into      | APB psel/penable   | pages_in_use at byte address 0
//
//  Cycles: a query takes 4, a reserve 3 plus one per page written and a free 5 plus one
//  per page cleared; an allocate adds 2 per page counted, 1 per page marked and 2 per
//  page searched, up to roughly 5 x 1024; the single page table port sets these figures.
//  Reset: a clearing pass writes zero to all 1024 entries, 1024 cycles, before the
//  first transaction is accepted; configuration writes are taken throughout.
//  Stalls: a result waits in the output register; the next one waits for it to drain.
module page_span_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    req_type,
    input  logic [psa_pkg::ADDR_W-1:0]    byte_address,
    input  logic [psa_pkg::BYTES_W-1:0]   request_bytes,
    input  logic [psa_pkg::PIU_W-1:0]     pages_done,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [psa_pkg::ADDR_W-1:0]    span_address,
    output logic [psa_pkg::BYTES_W-1:0]   span_bytes,
    output logic [psa_pkg::PIU_W-1:0]     pages_done_next,
    output logic [psa_pkg::BYTES_W-1:0]   entry_bytes,
    output logic [1:0]                    status,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [1:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    import psa_pkg::*;

    state_t               state_reg, state_next;
    logic [PIU_W-1:0]     piu_reg;
    logic [CNT_W-1:0]     lowest_reg, lowest_next;
    logic                 none_reg, none_next;

    // Captured transaction
    logic [1:0]           req_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [BYTES_W-1:0]   rb_reg;
    logic [PIU_W-1:0]     done_reg;

    // Sequencer working registers
    logic [CNT_W-1:0]     ptr_reg, ptr_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     start_reg, start_next;
    logic [CNT_W-1:0]     need_reg, need_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [BYTES_W-1:0]   size_reg, size_next;

    // Pending result fields
    logic [ADDR_W-1:0]    r_addr_reg, r_addr_next;
    logic [BYTES_W-1:0]   r_bytes_reg, r_bytes_next;
    logic [PIU_W-1:0]     r_pdn_reg, r_pdn_next;
    logic [BYTES_W-1:0]   r_entry_reg, r_entry_next;
    logic [1:0]           r_status_reg, r_status_next;

    logic                 out_valid_reg;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr, ram_raddr;
    logic [BYTES_W-1:0]   ram_wdata, ram_rdata;

    // Derived values
    logic [CNT_W-1:0]     len;
    logic [CNT_W-1:0]     idx;
    logic [CNT_W-1:0]     room;
    logic [BYTES_W:0]     rsize;
    logic [CNT_W+1:0]     rpages;
    logic [BYTES_W-1:0]   cap;
    logic [CNT_W-1:0]     total;
    logic [CNT_W-1:0]     probe;
    logic [CNT_W-1:0]     fpages;
    logic                 accept;
    logic                 push;

    assign len    = (piu_reg < PIU_W'(PAGES)) ? CNT_W'(piu_reg) : CNT_W'(PAGES);
    assign idx    = CNT_W'(addr_reg[ADDR_W-1:PAGE_SHIFT]);
    assign room   = len - idx;
    assign rsize  = {1'b0, rb_reg} + (BYTES_W+1)'(addr_reg[PAGE_SHIFT-1:0]);
    assign rpages = (CNT_W+2)'(rsize[BYTES_W:PAGE_SHIFT])
                  + (CNT_W+2)'(|rsize[PAGE_SHIFT-1:0]);
    assign cap    = BYTES_W'({room, {PAGE_SHIFT{1'b0}}});
    assign total  = CNT_W'(rb_reg[BYTES_W-1:PAGE_SHIFT]);
    assign probe  = start_reg + n_reg;
    assign fpages = CNT_W'(ram_rdata[BYTES_W-1:PAGE_SHIFT]);

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign push     = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    assign pready = 1'b1;
    assign prdata = 32'(piu_reg);

    psa_ram #(
        .WIDTH (BYTES_W),
        .DEPTH (PAGES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        lowest_next   = lowest_reg;
        none_next     = none_reg;
        ptr_next      = ptr_reg;
        cnt_next      = cnt_reg;
        start_next    = start_reg;
        need_next     = need_reg;
        n_next        = n_reg;
        size_next     = size_reg;
        r_addr_next   = r_addr_reg;
        r_bytes_next  = r_bytes_reg;
        r_pdn_next    = r_pdn_reg;
        r_entry_next  = r_entry_reg;
        r_status_next = r_status_reg;
        ram_we        = 1'b0;
        ram_waddr     = ptr_reg[IDX_W-1:0];
        ram_wdata     = size_reg;
        ram_raddr     = ptr_reg[IDX_W-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                // Sweep zeros through the table after reset
                ram_we    = 1'b1;
                ram_wdata = '0;
                ptr_next  = ptr_reg + 1'b1;
                if (ptr_reg == CNT_W'(PAGES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                r_addr_next   = '0;
                r_bytes_next  = '0;
                r_pdn_next    = '0;
                r_entry_next  = '0;
                r_status_next = ST_OK;
                state_next    = S_DONE;
                ptr_next      = idx;
                case (req_reg)
                    REQ_RESERVE:
                    begin
                        if (idx < len)
                        begin
                            cnt_next  = (rpages > (CNT_W+2)'(room)) ? room
                                                                    : CNT_W'(rpages);
                            size_next = (rsize > (BYTES_W+1)'(cap)) ? cap
                                                                   : BYTES_W'(rsize);
                            if (rpages != '0)
                            begin
                                state_next = S_RFILL;
                            end
                        end
                    end
                    REQ_ALLOC:
                    begin
                        r_pdn_next = done_reg;
                        if (CNT_W'(done_reg) >= total)
                        begin
                            r_status_next = ST_COMPLETE;
                        end
                        else if (none_reg)
                        begin
                            r_status_next = ST_FULL;
                        end
                        else
                        begin
                            start_next = lowest_reg;
                            need_next  = total - CNT_W'(done_reg);
                            n_next     = '0;
                            state_next = S_ACNT_RD;
                        end
                    end
                    REQ_FREE:
                    begin
                        if (idx < len)
                        begin
                            state_next = S_FREE_RD;
                        end
                    end
                    default:
                    begin
                        if (idx < len)
                        begin
                            state_next = S_QRY_RD;
                        end
                    end
                endcase
            end
            S_RFILL, S_FREE_CLR:
            begin
                ram_we    = 1'b1;
                ram_wdata = (state_reg == S_RFILL) ? size_reg : '0;
                ptr_next  = ptr_reg + 1'b1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = S_DONE;
                end
            end
            S_ACNT_RD:
            begin
                ram_raddr = probe[IDX_W-1:0];
                if ((n_reg < need_reg) && (probe < len))
                begin
                    state_next = S_ACNT_CHK;
                end
                else
                begin
                    state_next = S_AEND;
                end
            end
            S_ACNT_CHK:
            begin
                if (ram_rdata == '0)
                begin
                    n_next     = n_reg + 1'b1;
                    state_next = S_ACNT_RD;
                end
                else
                begin
                    state_next = S_AEND;
                end
            end
            S_AEND:
            begin
                r_pdn_next = r_pdn_reg + PIU_W'(n_reg);
                ptr_next   = start_reg;
                cnt_next   = n_reg;
                size_next  = BYTES_W'({n_reg, {PAGE_SHIFT{1'b0}}});
                if (n_reg != '0)
                begin
                    r_addr_next  = ADDR_W'({start_reg[IDX_W-1:0], {PAGE_SHIFT{1'b0}}});
                    r_bytes_next = BYTES_W'({n_reg, {PAGE_SHIFT{1'b0}}});
                    state_next   = S_AFILL;
                end
                else
                begin
                    state_next = S_FWD_RD;
                end
            end
            S_AFILL:
            begin
                ram_we   = 1'b1;
                ptr_next = ptr_reg + 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    ptr_next   = start_reg;
                    state_next = S_FWD_RD;
                end
            end
            S_FWD_RD:
            begin
                state_next = (ptr_reg < len) ? S_FWD_CHK : S_BSET;
            end
            S_FWD_CHK:
            begin
                if (ram_rdata == '0)
                begin
                    lowest_next = ptr_reg;
                    state_next  = S_DONE;
                end
                else
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = S_FWD_RD;
                end
            end
            S_BSET:
            begin
                if (len == '0)
                begin
                    none_next  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ptr_next   = (start_reg < len) ? start_reg : len - 1'b1;
                    state_next = S_BWD_RD;
                end
            end
            S_BWD_RD:
            begin
                state_next = S_BWD_CHK;
            end
            S_BWD_CHK:
            begin
                if (ram_rdata == '0)
                begin
                    lowest_next = ptr_reg;
                    state_next  = S_DONE;
                end
                else if (ptr_reg == '0)
                begin
                    none_next  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ptr_next   = ptr_reg - 1'b1;
                    state_next = S_BWD_RD;
                end
            end
            S_FREE_RD, S_QRY_RD:
            begin
                state_next = (state_reg == S_FREE_RD) ? S_FREE_CHK : S_BWD_RD;
                if (state_reg == S_QRY_RD)
                begin
                    state_next = S_DONE;
                end
            end
            S_FREE_CHK:
            begin
                cnt_next   = (fpages > room) ? room : fpages;
                state_next = S_DONE;
                if (fpages != '0)
                begin
                    state_next = S_FREE_CLR;
                    if (none_reg)
                    begin
                        none_next   = 1'b0;
                        lowest_next = idx;
                    end
                end
            end
            S_DONE:
            begin
                if (push)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Query data arrives the cycle after the read address is issued
    logic qry_land_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ptr_reg       <= '0;
            lowest_reg    <= '0;
            none_reg      <= 1'b0;
            piu_reg       <= PIU_RESET;
            out_valid_reg <= 1'b0;
            qry_land_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            lowest_reg   <= lowest_next;
            none_reg     <= none_next;
            qry_land_reg <= (state_reg == S_QRY_RD);
            if (psel && penable && pwrite && pready)
            begin
                piu_reg <= pwdata[PIU_W-1:0];
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= req_type;
            addr_reg <= byte_address;
            rb_reg   <= request_bytes;
            done_reg <= pages_done;
        end
        cnt_reg      <= cnt_next;
        start_reg    <= start_next;
        need_reg     <= need_next;
        n_reg        <= n_next;
        size_reg     <= size_next;
        r_addr_reg   <= r_addr_next;
        r_bytes_reg  <= r_bytes_next;
        r_pdn_reg    <= r_pdn_next;
        r_entry_reg  <= qry_land_reg ? ram_rdata : r_entry_next;
        r_status_reg <= r_status_next;
        if (push)
        begin
            span_address    <= r_addr_reg;
            span_bytes      <= r_bytes_reg;
            pages_done_next <= r_pdn_reg;
            entry_bytes     <= qry_land_reg ? ram_rdata : r_entry_reg;
            status          <= r_status_reg;
        end
    end

    assign out_valid = out_valid_reg;

    // Table writes happen only while a transaction or the clearing pass is at work
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg != S_IDLE) && (state_reg != S_DONE))
        else $error("page table written while idle");

    // A result is loaded only on leaving the completion state
    a_push_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion");

    // Marking starts only for a non-empty run
    a_fill_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_AFILL) |-> (cnt_reg != '0) && (n_reg != '0))
        else $error("allocate fill with empty run");

    // A pointer found by the forward search lies inside the table
    a_fwd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FWD_CHK) |-> (ptr_reg < len))
        else $error("forward search beyond table end");

endmodule

>>> sim/tb_page_span_allocator.sv
// Self-checking testbench for the page span allocator: queued driver, monitor, predictor.
`timescale 1ns / 100ps

module tb_page_span_allocator;
    import psa_pkg::*;

    // Stimulus and result record types
    typedef struct packed {
        logic [1:0]         req;
        logic [ADDR_W-1:0]  addr;
        logic [BYTES_W-1:0] nbytes;
        logic [PIU_W-1:0]   done;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  sp_addr;
        logic [BYTES_W-1:0] sp_bytes;
        logic [PIU_W-1:0]   next;
        logic [BYTES_W-1:0] entry;
        logic [1:0]         st;
    } res_t;

    localparam int LIMIT = 20_000_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] req_type = '0;
    logic [ADDR_W-1:0] byte_address = '0;
    logic [BYTES_W-1:0] request_bytes = '0;
    logic [PIU_W-1:0] pages_done = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [ADDR_W-1:0] span_address;
    logic [BYTES_W-1:0] span_bytes;
    logic [PIU_W-1:0] pages_done_next;
    logic [BYTES_W-1:0] entry_bytes;
    logic [1:0] status;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    page_span_allocator i_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    // Predictor state: its own copy of the page table and pointers
    logic [BYTES_W-1:0] pt [PAGES];
    int unsigned lowest_free_p;
    bit none_free_p;
    int unsigned pages_cfg;

    req_t pending_reqs[$];
    res_t expected_results[$];
    int unsigned n_fail = 0;
    int unsigned n_checked = 0;
    int unsigned n_sent = 0;
    int unsigned n_alloc = 0;
    int unsigned n_full = 0;
    longint unsigned cycles = 0;
    bit feeding = 1'b0;
    bit hold_off = 1'b0;

    function automatic int unsigned usable_len();
        return pages_cfg < PAGES ? pages_cfg : PAGES;
    endfunction

    // Hunt for the new lowest free page, forward first, then backward to page 0
    function automatic void seek_free(int unsigned from);
        int unsigned len;
        int i;
        len = usable_len();
        for (i = from; i < len; i++)
            if (pt[i] == 0)
            begin
                lowest_free_p = i;
                return;
            end
        if (len != 0)
        begin
            for (i = (from < len) ? from : len - 1; i >= 0; i--)
                if (pt[i] == 0)
                begin
                    lowest_free_p = i;
                    return;
                end
        end
        none_free_p = 1'b1;
    endfunction

    function automatic res_t predict_span(req_t r);
        res_t o;
        int unsigned len, idx, size, np, room, total, need, n, s;
        o = '0;
        len = usable_len();
        idx = r.addr >> PAGE_SHIFT;
        case (r.req)
            REQ_RESERVE:
                if (idx < len)
                begin
                    size = r.nbytes + (r.addr & 12'hfff);
                    np = (size >> PAGE_SHIFT) + ((size & 12'hfff) != 0);
                    room = len - idx;
                    if (np > room) np = room;
                    if (size > (room << PAGE_SHIFT)) size = room << PAGE_SHIFT;
                    for (int i = 0; i < np; i++) pt[idx + i] = BYTES_W'(size);
                end
            REQ_ALLOC:
            begin
                total = r.nbytes >> PAGE_SHIFT;
                o.next = r.done;
                if (r.done >= total) o.st = ST_COMPLETE;
                else if (none_free_p) o.st = ST_FULL;
                else
                begin
                    s = lowest_free_p;
                    need = total - r.done;
                    n = 0;
                    while (n < need && s + n < len && pt[s + n] == 0) n++;
                    for (int i = 0; i < n; i++) pt[s + i] = BYTES_W'(n << PAGE_SHIFT);
                    o.next = PIU_W'(r.done + n);
                    if (n != 0)
                    begin
                        o.sp_addr = ADDR_W'(s << PAGE_SHIFT);
                        o.sp_bytes = BYTES_W'(n << PAGE_SHIFT);
                    end
                    seek_free(s);
                end
            end
            REQ_FREE:
                if (idx < len)
                begin
                    n = pt[idx] >> PAGE_SHIFT;
                    room = len - idx;
                    if (n > room) n = room;
                    for (int i = 0; i < n; i++) pt[idx + i] = '0;
                    if (none_free_p && n != 0)
                    begin
                        none_free_p = 1'b0;
                        lowest_free_p = idx;
                    end
                end
            default:
                o.entry = (idx < len) ? pt[idx] : '0;
        endcase
        return o;
    endfunction

    // Gap length: mostly short, sometimes long
    function automatic int unsigned pick_gap();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Driver: offer queued transactions, hold payload while stalled
    int unsigned in_gap = 0;
    always @(posedge clk)
    begin
        req_t r;
        if (in_valid && !in_stall)
        begin
            expected_results.push_back(predict_span(pending_reqs.pop_front()));
            n_sent++;
            in_gap = pick_gap();
        end
        if (in_valid && in_stall)
            ;
        else if (feeding && pending_reqs.size() != 0 && in_gap == 0)
        begin
            r = pending_reqs[0];
            in_valid <= 1'b1;
            req_type <= r.req;
            byte_address <= r.addr;
            request_bytes <= r.nbytes;
            pages_done <= r.done;
        end
        else
        begin
            in_valid <= 1'b0;
            if (in_gap != 0) in_gap--;
        end
    end

    // Monitor: compare each accepted result against the oldest prediction
    int unsigned out_gap = 0;
    always @(posedge clk)
    begin
        res_t got, want;
        cycles++;
        if (out_valid && !out_stall)
        begin
            got = '{span_address, span_bytes, pages_done_next, entry_bytes, status};
            if (expected_results.size() == 0)
            begin
                n_fail++;
                if (n_fail <= 10) $display("unexpected result %h", got);
            end
            else
            begin
                want = expected_results.pop_front();
                n_checked++;
                if (status == ST_FULL) n_full++;
                if (span_bytes != 0) n_alloc++;
                if (got !== want)
                begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("mismatch: expected %h actual %h", want, got);
                end
            end
            out_gap = pick_gap();
        end
        if (hold_off) out_stall <= 1'b1;
        else if (out_gap != 0)
        begin
            out_stall <= 1'b1;
            out_gap--;
        end
        else out_stall <= 1'b0;
    end

    // Long receiver hold-off so that the block backs up into its input
    initial
    begin
        wait (n_sent == 150);
        hold_off = 1'b1;
        repeat (20000) @(posedge clk);
        hold_off = 1'b0;
    end

    always @(posedge clk)
        if (cycles > LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end

    task automatic apb_write(input logic [31:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        pages_cfg = v & 32'h7ff;
    endtask

    // Run one phase: feed the queued items, let them drain, then let the block settle
    task automatic run_phase();
        feeding = 1'b1;
        wait (pending_reqs.size() == 0 && expected_results.size() == 0);
        feeding = 1'b0;
        repeat (6000) @(posedge clk);
    endtask

    function automatic req_t mk(logic [1:0] t, int unsigned a, int unsigned b,
                                int unsigned d);
        req_t r;
        r.req = t;
        r.addr = ADDR_W'(a);
        r.nbytes = BYTES_W'(b);
        r.done = PIU_W'(d);
        return r;
    endfunction

    // Random item: mostly allocates and frees of small spans, with pages up to just past the table end
    function automatic req_t rand_req();
        int unsigned p, len, page;
        p = $urandom_range(0, 99);
        len = usable_len();
        page = $urandom_range(0, len + 2);
        if (p < 4)
            return mk(2'($urandom_range(0, 3)), $urandom(), $urandom_range(0, 23'h7fffff),
                      $urandom());
        if (p < 40)
            return mk(REQ_ALLOC, 0, $urandom_range(0, 12) << PAGE_SHIFT | $urandom_range(0, 4095),
                      $urandom_range(0, 4));
        if (p < 70)
            return mk(REQ_FREE, (page << PAGE_SHIFT) | $urandom_range(0, 4095), 0, 0);
        if (p < 85)
            return mk(REQ_QUERY, (page << PAGE_SHIFT) | $urandom_range(0, 4095), 0, 0);
        return mk(REQ_RESERVE, (page << PAGE_SHIFT) | $urandom_range(0, 4095),
                  $urandom_range(0, 6 << PAGE_SHIFT), 0);
    endfunction

    initial
    begin
        int unsigned cfgs[5] = '{1024, 1, 40, 2047, 17};
        for (int i = 0; i < PAGES; i++) pt[i] = '0;
        lowest_free_p = 0;
        none_free_p = 1'b0;
        pages_cfg = PIU_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every request, saturation, full table, complete
        pending_reqs.push_back(mk(REQ_QUERY, 22'h3fffff, 0, 0));
        pending_reqs.push_back(mk(REQ_ALLOC, 0, 3 << PAGE_SHIFT, 3));
        pending_reqs.push_back(mk(REQ_ALLOC, 0, 23'h7fffff, 2047));
        pending_reqs.push_back(mk(REQ_ALLOC, 0, 4095, 0));
        pending_reqs.push_back(mk(REQ_ALLOC, 0, 5 << PAGE_SHIFT, 0));
        pending_reqs.push_back(mk(REQ_RESERVE, 22'h3ff800, 23'h400000, 0));
        pending_reqs.push_back(mk(REQ_QUERY, 22'h3ff000, 0, 0));
        pending_reqs.push_back(mk(REQ_RESERVE, 22'h00a123, 23'h2000, 0));
        pending_reqs.push_back(mk(REQ_QUERY, 22'h00c000, 0, 0));
        pending_reqs.push_back(mk(REQ_ALLOC, 0, 23'h400000, 0));
        pending_reqs.push_back(mk(REQ_ALLOC, 0, 23'h400000, 100));
        pending_reqs.push_back(mk(REQ_ALLOC, 0, 23'h400000, 1000));
        pending_reqs.push_back(mk(REQ_FREE, 22'h005000, 0, 0));
        pending_reqs.push_back(mk(REQ_FREE, 22'h3ff000, 0, 0));
        pending_reqs.push_back(mk(REQ_ALLOC, 0, 2 << PAGE_SHIFT, 0));
        pending_reqs.push_back(mk(REQ_FREE, 0, 0, 0));
        pending_reqs.push_back(mk(REQ_QUERY, 0, 0, 0));
        run_phase();

        for (int ph = 0; ph < 5; ph++)
        begin
            apb_write(cfgs[ph]);
            for (int k = 0; k < 112; k++) pending_reqs.push_back(rand_req());
            run_phase();
        end

        $display("covered %0d transactions, %0d results checked, %0d spans allocated,",
                 n_sent, n_checked, n_alloc);
        $display("%0d table-full replies, over the reset length and five written lengths",
                 n_full);
        if (n_fail == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
